>>> sv/bdc_pkg.sv
// ----------------------------------------------------------------------------
// bdc_pkg
// Types, register codes and reset values shared by the double-click detector.
// ----------------------------------------------------------------------------
package bdc_pkg;

   localparam int DEFAULT_NUM_SLOTS = 4;
   localparam int SLOT_W            = 2;
   localparam int STAMP_W           = 32;
   localparam int GAP_W             = 16;
   localparam int CSR_INDEX_W       = 4;
   localparam int CSR_DATA_W        = GAP_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_LEVEL     = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_PRESS_GAP  = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_PRESS_GAP = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEQUENCE_TIMEOUT = 4'd3;

   localparam logic             RESET_ACTIVE_LEVEL     = 1'b0;
   localparam logic [GAP_W-1:0] RESET_FIRST_PRESS_GAP  = 16'd50;
   localparam logic [GAP_W-1:0] RESET_SECOND_PRESS_GAP = 16'd50;
   localparam logic [GAP_W-1:0] RESET_SEQUENCE_TIMEOUT = 16'd500;

   typedef enum logic [1:0] {
      PHASE_IDLE   = 2'd0,
      PHASE_FIRST  = 2'd1,
      PHASE_WAIT   = 2'd2,
      PHASE_SECOND = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic [STAMP_W-1:0] stamp;
   } slot_entry_type;

   typedef struct packed {
      logic             active_level;
      logic [GAP_W-1:0] first_press_gap;
      logic [GAP_W-1:0] second_press_gap;
      logic [GAP_W-1:0] sequence_timeout;
   } cfg_type;

endpackage

>>> sv/bdc_ram.sv
// ----------------------------------------------------------------------------
// bdc_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module bdc_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 4,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/bdc_step.sv
// ----------------------------------------------------------------------------
// bdc_step
// Next-state logic for one slot: timeout, then the four-phase click sequence.
// ----------------------------------------------------------------------------
module bdc_step import bdc_pkg::*; (
   input  cfg_type             cfg,
   input  slot_entry_type      cur,
   input  logic [STAMP_W-1:0]  now_ms,
   input  logic                pin_level,
   output slot_entry_type      nxt,
   output logic                hit
);

   logic               pressed;
   logic [STAMP_W-1:0] elapsed;
   logic               timed_out;
   logic [STAMP_W-1:0] elapsed_eff;
   slot_entry_type     base;

   always_comb begin
      pressed     = (pin_level == cfg.active_level);
      elapsed     = now_ms - cur.stamp;
      timed_out   = (cur.phase != PHASE_IDLE) &&
                    (elapsed >= {{(STAMP_W-GAP_W){1'b0}}, cfg.sequence_timeout});
      base        = cur;
      elapsed_eff = elapsed;
      if (timed_out) begin
         base.phase  = PHASE_IDLE;
         base.stamp  = now_ms;
         elapsed_eff = '0;
      end

      nxt = base;
      hit = 1'b0;
      unique case (base.phase)
         PHASE_IDLE: begin
            if (pressed &&
                elapsed_eff >= {{(STAMP_W-GAP_W){1'b0}}, cfg.first_press_gap}) begin
               nxt.phase = PHASE_FIRST;
               nxt.stamp = now_ms;
            end
         end
         PHASE_FIRST: begin
            if (!pressed) begin
               nxt.phase = PHASE_WAIT;
            end
         end
         PHASE_WAIT: begin
            if (pressed &&
                elapsed_eff >= {{(STAMP_W-GAP_W){1'b0}}, cfg.second_press_gap}) begin
               nxt.phase = PHASE_SECOND;
               nxt.stamp = now_ms;
               hit       = 1'b1;
            end
         end
         PHASE_SECOND: begin
            if (!pressed) begin
               nxt.phase = PHASE_IDLE;
            end
         end
         default: begin
            nxt.phase = PHASE_IDLE;
         end
      endcase
   end

endmodule

>>> sv/button_double_click_detector_unit.sv
// ----------------------------------------------------------------------------
// button_double_click_detector_unit
// Polled double-click detector for several independent buttons.
// ----------------------------------------------------------------------------
// One poll word is accepted each clock cycle unless a stalled response holds
// the update stage; each poll yields one response word. The slot entry is
// read from the state RAM in the accept cycle and written back updated when
// that stage advances; the previous write is forwarded so that polls of one
// slot back to back see fresh state. The output register lets a new poll
// enter while a response waits. Per-slot valid flags make every slot read
// as idle with a zero stamp after reset, so no clearing pass is needed.
module button_double_click_detector_unit import bdc_pkg::*; #(
   parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SLOT_W-1:0]      req_slot,
   input  logic [STAMP_W-1:0]     req_now_ms,
   input  logic                   req_pin_level,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_double_click,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ADDR_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SLOT_EXT_W = 8;
   localparam int ENTRY_W    = $bits(slot_entry_type);

   cfg_type cfg_ff;

   logic                 s1_valid_ff;
   logic [SLOT_W-1:0]    s1_slot_ff;
   logic [STAMP_W-1:0]   s1_now_ff;
   logic                 s1_pin_ff;

   logic                 fwd_valid_ff;
   logic [ADDR_W-1:0]    fwd_addr_ff;
   slot_entry_type       fwd_data_ff;
   logic [NUM_SLOTS-1:0] valid_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic                 rsp_valid_in;

   logic                 req_accept;
   logic                 s1_advance;
   logic [SLOT_EXT_W-1:0] req_slot_ext;
   logic [SLOT_EXT_W-1:0] s1_slot_ext;
   logic [ADDR_W-1:0]    req_addr;
   logic [ADDR_W-1:0]    s1_addr;
   logic                 s1_in_range;
   logic [ENTRY_W-1:0]   ram_rd_data;
   logic                 ram_wr_en;
   slot_entry_type       s1_cur;
   slot_entry_type       step_nxt;
   logic                 step_hit;

   assign req_slot_ext = {{(SLOT_EXT_W-SLOT_W){1'b0}}, req_slot};
   assign s1_slot_ext  = {{(SLOT_EXT_W-SLOT_W){1'b0}}, s1_slot_ff};
   assign req_addr     = req_slot_ext[ADDR_W-1:0];
   assign s1_addr      = s1_slot_ext[ADDR_W-1:0];
   assign s1_in_range  = s1_slot_ext < SLOT_EXT_W'(NUM_SLOTS);

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_accept = req_valid && req_ready;
   assign ram_wr_en  = s1_advance && s1_in_range;

   always_comb begin
      s1_cur = '0;
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr)) begin
         s1_cur = fwd_data_ff;
      end else if (s1_in_range && valid_ff[s1_addr]) begin
         s1_cur = slot_entry_type'(ram_rd_data);
      end
   end

   bdc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_addr),
      .wr_data (step_nxt),
      .rd_en   (req_accept),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   bdc_step u_step (
      .cfg       (cfg_ff),
      .cur       (s1_cur),
      .now_ms    (s1_now_ff),
      .pin_level (s1_pin_ff),
      .nxt       (step_nxt),
      .hit       (step_hit)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_level     <= RESET_ACTIVE_LEVEL;
         cfg_ff.first_press_gap  <= RESET_FIRST_PRESS_GAP;
         cfg_ff.second_press_gap <= RESET_SECOND_PRESS_GAP;
         cfg_ff.sequence_timeout <= RESET_SEQUENCE_TIMEOUT;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ACTIVE_LEVEL:     cfg_ff.active_level     <= csr_wdata[0];
            CSR_FIRST_PRESS_GAP:  cfg_ff.first_press_gap  <= csr_wdata;
            CSR_SECOND_PRESS_GAP: cfg_ff.second_press_gap <= csr_wdata;
            CSR_SEQUENCE_TIMEOUT: cfg_ff.sequence_timeout <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (ram_wr_en) begin
            fwd_valid_ff      <= 1'b1;
            valid_ff[s1_addr] <= 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_slot_ff <= req_slot;
         s1_now_ff  <= req_now_ms;
         s1_pin_ff  <= req_pin_level;
      end
      if (ram_wr_en) begin
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= step_nxt;
      end
      if (s1_advance) begin
         rsp_hit_ff <= step_hit && s1_in_range;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_double_click = rsp_hit_ff;

   a_accept_fills_stage: assert property (
      @(posedge clock) disable iff (reset) req_accept |=> s1_valid_ff
   ) else $error("Accepted poll did not reach the update stage.");

   a_stalled_stage_holds: assert property (
      @(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=>
         (s1_valid_ff && $stable(s1_slot_ff) && $stable(s1_now_ff))
   ) else $error("Update stage changed while stalled.");

   a_hit_from_wait: assert property (
      @(posedge clock) disable iff (reset)
      (s1_advance && step_hit && s1_in_range) |-> (s1_cur.phase == PHASE_WAIT)
   ) else $error("Double click reported from a phase other than waiting.");

   a_forward_tracks_write: assert property (
      @(posedge clock) disable iff (reset)
      ram_wr_en |=> (fwd_valid_ff && (fwd_addr_ff == $past(s1_addr)))
   ) else $error("Forward register does not hold the last write.");

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polled double-click detector.
// ----------------------------------------------------------------------------
// Polls are queued by a stimulus process and presented by a driver on the
// falling edge, and a monitor on the rising edge predicts and checks each
// response word. The bench runs a directed sequence, then click sequences and
// noise under several register settings and several idling patterns. One
// phase also holds the response channel off for a long stretch.
module tb;
   import bdc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 4000;
   localparam int LONG_HOLD   = 300;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNUSED = CSR_SEQUENCE_TIMEOUT + 1'b1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_INDEX   = {CSR_INDEX_W{1'b1}};
   localparam int SEND_IDLE[4] = '{0, 87, 0, 33};
   localparam int RECV_STALL[4] = '{0, 0, 87, 33};

   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic [STAMP_W-1:0] now_ms;
      logic               pin_level;
   } poll_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [SLOT_W-1:0]      req_slot = '0;
   logic [STAMP_W-1:0]     req_now_ms = '0;
   logic                   req_pin_level = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_double_click;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   poll_word_type      poll_fifo[$];
   logic               expected_clicks[$];
   cfg_type            cfg_shadow;
   phase_type          slot_phase[DEFAULT_NUM_SLOTS];
   logic [STAMP_W-1:0] slot_stamp[DEFAULT_NUM_SLOTS];
   logic [STAMP_W-1:0] slot_time[DEFAULT_NUM_SLOTS];

   int   polls_queued = 0;
   int   polls_accepted = 0;
   int   quiet_cycles = 0;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   hold_ticket = 0;
   int   hold_served = 0;
   int   hold_left = 0;
   logic req_taken = 1'b0;
   logic failed = 1'b0;

   button_double_click_detector_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_slot         (req_slot),
      .req_now_ms       (req_now_ms),
      .req_pin_level    (req_pin_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_double_click (rsp_double_click),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic predict_click(logic [SLOT_W-1:0] s, logic [STAMP_W-1:0] now,
                                          logic pin);
      phase_type p;
      logic      pressed;
      logic      hit;
      p = slot_phase[s];
      pressed = (pin == cfg_shadow.active_level);
      hit = 1'b0;
      if (p != PHASE_IDLE && (now - slot_stamp[s]) >= cfg_shadow.sequence_timeout) begin
         p = PHASE_IDLE;
         slot_stamp[s] = now;
      end
      case (p)
         PHASE_IDLE: begin
            if (pressed && (now - slot_stamp[s]) >= cfg_shadow.first_press_gap) begin
               p = PHASE_FIRST;
               slot_stamp[s] = now;
            end
         end
         PHASE_FIRST: begin
            if (!pressed) p = PHASE_WAIT;
         end
         PHASE_WAIT: begin
            if (pressed && (now - slot_stamp[s]) >= cfg_shadow.second_press_gap) begin
               p = PHASE_SECOND;
               slot_stamp[s] = now;
               hit = 1'b1;
            end
         end
         default: begin
            if (!pressed) p = PHASE_IDLE;
         end
      endcase
      slot_phase[s] = p;
      return hit;
   endfunction

   // Distance to the next press, clustered around the given gap or the timeout.
   function automatic logic [STAMP_W-1:0] gap_step(logic [GAP_W-1:0] gap);
      case ($urandom_range(4))
         0: return (gap == 0) ? '0 : STAMP_W'(gap) - 1;
         1: return STAMP_W'(gap);
         2: return STAMP_W'(gap) + $urandom_range(15);
         3: return $urandom_range(2 * int'(gap) + 40);
         default: return STAMP_W'(cfg_shadow.sequence_timeout) + $urandom_range(2) - 1;
      endcase
   endfunction

   task automatic queue_poll(logic [SLOT_W-1:0] s, logic [STAMP_W-1:0] now, logic pin);
      poll_fifo.push_back('{slot: s, now_ms: now, pin_level: pin});
      polls_queued++;
   endtask

   task automatic queue_click_sequence();
      logic [SLOT_W-1:0]  s;
      logic               act;
      logic [STAMP_W-1:0] press_time;
      logic [STAMP_W-1:0] offset;
      logic [STAMP_W-1:0] second;
      s = SLOT_W'($urandom_range(DEFAULT_NUM_SLOTS - 1));
      act = cfg_shadow.active_level;
      slot_time[s] += gap_step(cfg_shadow.first_press_gap);
      press_time = slot_time[s];
      offset = '0;
      queue_poll(s, press_time, act);
      repeat ($urandom_range(2)) begin
         offset += $urandom_range(5);
         queue_poll(s, press_time + offset, act);
      end
      repeat ($urandom_range(1, 2)) begin
         offset += $urandom_range(8);
         queue_poll(s, press_time + offset, !act);
      end
      second = gap_step(cfg_shadow.second_press_gap);
      if (second <= offset) second = offset + 1;
      offset = second;
      queue_poll(s, press_time + offset, act);
      repeat ($urandom_range(2)) begin
         offset += $urandom_range(5);
         queue_poll(s, press_time + offset, act);
      end
      offset += $urandom_range(1, 8);
      queue_poll(s, press_time + offset, !act);
      slot_time[s] = press_time + offset;
   endtask

   task automatic queue_random_polls(int count);
      int goal;
      goal = polls_queued + count;
      foreach (slot_time[k]) slot_time[k] = $urandom;
      while (polls_queued < goal) begin
         if ($urandom_range(9) == 0)
            queue_poll(SLOT_W'($urandom_range(DEFAULT_NUM_SLOTS - 1)), $urandom,
                       1'($urandom_range(1)));
         else
            queue_click_sequence();
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (polls_accepted != polls_queued || expected_clicks.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_ACTIVE_LEVEL:     cfg_shadow.active_level = data[0];
         CSR_FIRST_PRESS_GAP:  cfg_shadow.first_press_gap = data;
         CSR_SECOND_PRESS_GAP: cfg_shadow.second_press_gap = data;
         CSR_SEQUENCE_TIMEOUT: cfg_shadow.sequence_timeout = data;
         default: ;
      endcase
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // The level register only keeps bit 0, so the upper bits carry noise.
   task automatic load_settings(logic level, logic [GAP_W-1:0] first_gap,
                                logic [GAP_W-1:0] second_gap, logic [GAP_W-1:0] timeout);
      write_csr(CSR_ACTIVE_LEVEL, (CSR_DATA_W'($urandom) & ~CSR_DATA_W'(1)) | level);
      write_csr(CSR_FIRST_PRESS_GAP, first_gap);
      write_csr(CSR_SECOND_PRESS_GAP, second_gap);
      write_csr(CSR_SEQUENCE_TIMEOUT, timeout);
   endtask

   task automatic set_idling(int sender_pct, int receiver_pct);
      send_idle_pct = sender_pct;
      rsp_stall_pct = receiver_pct;
   endtask

   always @(negedge clock) begin
      poll_word_type next_word;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (poll_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_word = poll_fifo.pop_front();
            req_valid <= 1'b1;
            req_slot <= next_word.slot;
            req_now_ms <= next_word.now_ms;
            req_pin_level <= next_word.pin_level;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_served != hold_ticket) begin
         hold_served = hold_ticket;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : monitor
      logic expected;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_clicks.size() == 0) begin
               $error("double_click: expected no word, got %0b", rsp_double_click);
               failed = 1'b1;
            end else begin
               expected = expected_clicks.pop_front();
               if (rsp_double_click !== expected) begin
                  $error("double_click: expected %0b, got %0b", expected, rsp_double_click);
                  failed = 1'b1;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_clicks.push_back(predict_click(req_slot, req_now_ms, req_pin_level));
            polls_accepted++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb failed");
            $finish;
         end
      end
   end

   initial begin
      int m;
      cfg_shadow.active_level = RESET_ACTIVE_LEVEL;
      cfg_shadow.first_press_gap = RESET_FIRST_PRESS_GAP;
      cfg_shadow.second_press_gap = RESET_SECOND_PRESS_GAP;
      cfg_shadow.sequence_timeout = RESET_SEQUENCE_TIMEOUT;
      foreach (slot_phase[k]) begin
         slot_phase[k] = PHASE_IDLE;
         slot_stamp[k] = '0;
      end
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // With the reset level a low pin counts as pressed.
      queue_poll(0, 49, 1'b0);
      queue_poll(0, 50, 1'b0);
      queue_poll(0, 60, 1'b1);
      queue_poll(0, 99, 1'b0);
      queue_poll(0, 100, 1'b0);
      queue_poll(0, 101, 1'b0);
      queue_poll(0, 110, 1'b1);
      queue_poll(1, 1000, 1'b0);
      queue_poll(1, 1010, 1'b1);
      queue_poll(1, 1500, 1'b0);
      queue_poll(1, 1550, 1'b0);
      queue_poll(2, 32'hFFFF_FFF0, 1'b0);
      queue_poll(2, 32'hFFFF_FFFF, 1'b1);
      queue_poll(2, 32'h0000_0022, 1'b0);
      queue_poll(2, 32'h0000_0023, 1'b1);
      queue_poll(3, 32'hFFFF_FFFF, 1'b0);
      queue_poll(3, 32'h0000_0000, 1'b1);
      queue_poll(3, 32'h0000_01F3, 1'b0);
      queue_poll(3, 32'h0000_01F4, 1'b1);
      wait_idle();

      queue_random_polls(250);
      wait_idle();

      set_idling(SEND_IDLE[1], RECV_STALL[1]);
      load_settings(1'b1, '0, '0, '0);
      queue_random_polls(150);
      wait_idle();

      set_idling(SEND_IDLE[2], RECV_STALL[2]);
      load_settings(1'b0, '1, '1, '1);
      queue_random_polls(150);
      wait_idle();

      set_idling(SEND_IDLE[3], RECV_STALL[3]);
      load_settings(1'b1, 20, 30, 200);
      write_csr(CSR_INDEX_W'($urandom_range(CSR_LAST_INDEX, CSR_FIRST_UNUSED)),
                CSR_DATA_W'($urandom));
      queue_random_polls(250);
      wait_idle();

      set_idling(SEND_IDLE[0], RECV_STALL[0]);
      load_settings(1'b0, 10, 15, 300);
      hold_ticket++;
      queue_random_polls(50);
      wait_idle();
      queue_random_polls(50);
      wait_idle();

      for (m = 0; m < 4; m++) begin
         set_idling(SEND_IDLE[m], RECV_STALL[m]);
         load_settings(1'($urandom_range(1)), GAP_W'($urandom_range(120)),
                       GAP_W'($urandom_range(120)),
                       GAP_W'(($urandom_range(9) == 0) ? $urandom_range(16'hFFFF)
                                                       : $urandom_range(900, 200)));
         queue_random_polls(140);
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (!failed) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
